>>> rtl/core/mnv_pkg.sv
// ----------------------------------------------------------------------------
// mnv_pkg: shared constants for the min/max viridis color mapper
// command codes, colormap knot tables and the depth of the item queue
// ----------------------------------------------------------------------------
package mnv_pkg;

  typedef enum logic [1:0] {
    CMD_SCAN  = 2'd0,
    CMD_MAP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // knots at t = 0, 1/4, 1/2, 3/4, 1
  localparam logic [7:0] KNOT_R [5] = '{8'd68, 8'd59, 8'd33, 8'd93, 8'd253};
  localparam logic [7:0] KNOT_G [5] = '{8'd1, 8'd82, 8'd144, 8'd201, 8'd231};
  localparam logic [7:0] KNOT_B [5] = '{8'd84, 8'd139, 8'd140, 8'd99, 8'd37};

  localparam int QUEUE_DEPTH = 4;

endpackage

>>> rtl/core/mnv_front.sv
// ----------------------------------------------------------------------------
// mnv_front: statistics and classification
// keeps running min/max, turns map words into (difference, range) pairs
// ----------------------------------------------------------------------------
module mnv_front #(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [1:0]                          cmd,
  input  logic [SAMPLE_WIDTH-1:0]             sample,
  output logic                                q_push,
  output logic signed [SAMPLE_WIDTH:0]        q_d,
  output logic [((SAMPLE_WIDTH > FRACTION_BITS) ? SAMPLE_WIDTH : FRACTION_BITS+1)-1:0] q_r
);

  localparam int RW = (SAMPLE_WIDTH > FRACTION_BITS) ? SAMPLE_WIDTH : FRACTION_BITS + 1;
  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] running_min;
  logic signed [SAMPLE_WIDTH-1:0] running_max;
  logic signed [SAMPLE_WIDTH-1:0] s;
  logic signed [SAMPLE_WIDTH:0]   span;

  assign s = $signed(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_min <= MOST_POS;
      running_max <= MOST_NEG;
    end else if (accept) begin
      unique case (cmd)
        mnv_pkg::CMD_CLEAR: begin
          running_min <= MOST_POS;
          running_max <= MOST_NEG;
        end
        mnv_pkg::CMD_SCAN: begin
          if (s < running_min) running_min <= s;
          if (s > running_max) running_max <= s;
        end
        default: ;
      endcase
    end
  end

  // exact differences, one bit wider than a sample
  assign q_d  = $signed({s[SAMPLE_WIDTH-1], s}) -
                $signed({running_min[SAMPLE_WIDTH-1], running_min});
  assign span = $signed({running_max[SAMPLE_WIDTH-1], running_max}) -
                $signed({running_min[SAMPLE_WIDTH-1], running_min});

  // empty or inverted span falls back to a range of 1.0
  assign q_r = (running_max > running_min) ? RW'(span[SAMPLE_WIDTH-1:0])
                                           : (RW'(1) << FRACTION_BITS);

  assign q_push = accept && (cmd == mnv_pkg::CMD_MAP);

  a_scan_orders_stats: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == mnv_pkg::CMD_SCAN) |=> (running_min <= running_max))
    else $error("min above max after scan");

endmodule

>>> rtl/core/mnv_queue.sv
// ----------------------------------------------------------------------------
// mnv_queue: short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module mnv_queue #(
  parameter int DATA_WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic                  pop,
  output logic [DATA_WIDTH-1:0] rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int DEPTH = mnv_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]         wr_ptr;
  logic [AW-1:0]         rd_ptr;
  logic [AW:0]           count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= rd_ptr + AW'(1);
      if (do_push && !do_pop) count <= count + (AW+1)'(1);
      else if (do_pop && !do_push) count <= count - (AW+1)'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("queue count above depth");

  a_pointer_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

>>> rtl/core/mnv_back.sv
// ----------------------------------------------------------------------------
// mnv_back: normalize and color
// serial restoring division, then piecewise-linear viridis lookup
// ----------------------------------------------------------------------------
module mnv_back #(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  logic signed [SAMPLE_WIDTH:0] q_d,
  input  logic [((SAMPLE_WIDTH > FRACTION_BITS) ? SAMPLE_WIDTH : FRACTION_BITS+1)-1:0] q_r,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         out_valid,
  output logic [23:0]                  color
);

  localparam int RW = (SAMPLE_WIDTH > FRACTION_BITS) ? SAMPLE_WIDTH : FRACTION_BITS + 1;
  localparam int FB = FRACTION_BITS;
  localparam int CW = $clog2(FB);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MAP
  } state_t;

  state_t                        state;
  logic signed [SAMPLE_WIDTH:0]  d_reg;
  logic [RW-1:0]                 r_reg;
  logic [RW-1:0]                 rem;
  logic [FB-1:0]                 quo;
  logic [FB:0]                   t;
  logic [CW-1:0]                 cnt;

  logic [RW-1:0]  d_mag;
  logic           d_pos;
  logic [RW:0]    rem_sh;
  logic           fits;
  logic [RW:0]    rem_sub;
  logic [FB-1:0]  quo_next;
  logic [1:0]     seg;
  logic [FB-2:0]  local_t;
  logic [7:0]     ch_r;
  logic [7:0]     ch_g;
  logic [7:0]     ch_b;
  logic           map_load;

  // one channel: floor((a*q + (b-a)*local) / q)
  function automatic logic [7:0] chan(input logic [7:0] a, input logic [7:0] b,
                                      input logic [FB-2:0] loc);
    logic signed [8:0]    dlt;
    logic signed [FB-1:0] ls;
    logic signed [FB+8:0] prod;
    logic signed [FB+8:0] base;
    logic signed [FB+8:0] num;
    dlt  = $signed({1'b0, b}) - $signed({1'b0, a});
    ls   = $signed({1'b0, loc});
    prod = dlt * ls;
    base = $signed({3'b000, a, {(FB-2){1'b0}}});
    num  = base + prod;
    return num[FB+5:FB-2];
  endfunction

  assign q_pop = (state == ST_IDLE) && !q_empty;

  assign d_mag    = RW'(d_reg[SAMPLE_WIDTH-1:0]);
  assign d_pos    = !d_reg[SAMPLE_WIDTH] && (d_reg != '0);
  assign rem_sh   = {rem, 1'b0};
  assign rem_sub  = rem_sh - {1'b0, r_reg};
  assign fits     = (rem_sh >= {1'b0, r_reg});
  assign quo_next = {quo[FB-2:0], fits};

  // a finished pixel loads once the output register is free or draining
  assign map_load = (state == ST_MAP) && (!out_valid || pop);

  // t = 1.0 stays on the last segment at its far end
  always_comb begin
    if (t[FB]) begin
      seg     = 2'd3;
      local_t = {1'b1, {(FB-2){1'b0}}};
    end else begin
      seg     = t[FB-1:FB-2];
      local_t = {1'b0, t[FB-3:0]};
    end
  end

  assign ch_r = chan(mnv_pkg::KNOT_R[{1'b0, seg}], mnv_pkg::KNOT_R[{1'b0, seg} + 3'd1], local_t);
  assign ch_g = chan(mnv_pkg::KNOT_G[{1'b0, seg}], mnv_pkg::KNOT_G[{1'b0, seg} + 3'd1], local_t);
  assign ch_b = chan(mnv_pkg::KNOT_B[{1'b0, seg}], mnv_pkg::KNOT_B[{1'b0, seg} + 3'd1], local_t);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (map_load) out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            d_reg <= q_d;
            r_reg <= q_r;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          priority if (!d_pos) begin
            t     <= '0;
            state <= ST_MAP;
          end else if (d_mag >= r_reg) begin
            t     <= {1'b1, {FB{1'b0}}};
            state <= ST_MAP;
          end else begin
            rem   <= d_mag;
            quo   <= '0;
            cnt   <= CW'(FB - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= fits ? rem_sub[RW-1:0] : rem_sh[RW-1:0];
          quo <= quo_next;
          if (cnt == '0) begin
            t     <= {1'b0, quo_next};
            state <= ST_MAP;
          end else begin
            cnt <= cnt - CW'(1);
          end
        end
        ST_MAP: begin
          // wait for the output register to drain
          if (map_load) begin
            color <= {ch_r, ch_g, ch_b};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_rem_below_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < r_reg))
    else $error("division remainder not below range");

  a_t_in_unit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAP) |-> (t <= {1'b1, {FB{1'b0}}}))
    else $error("normalized value above one");

endmodule

>>> rtl/core/minmax_normalize_viridis_colormap.sv
// ----------------------------------------------------------------------------
// minmax_normalize_viridis_colormap: min/max normalizing viridis color mapper
// scan words build running min/max, map words become packed rgb pixels
// ----------------------------------------------------------------------------
//
//  channel   handshake          fields                     notes
//  input     push / full        cmd[1:0], sample[SW-1:0]   scan, map or clear
//  result    empty / pop        color[23:0]                one word per map
//
//  scan and clear words are handled in the front and produce nothing
//  a map word passes through the back in order: dequeue, range
//  check, one quotient bit per cycle in the serial divider, then color lookup
//  samples that saturate to 0 or 1.0 skip the divider
//  the front keeps accepting while the queue has room, so scans overlap maps
//  rst is synchronous; it restores the statistics and empties queue and output
//
module minmax_normalize_viridis_colormap #(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              cmd,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  output logic                    empty,
  input  logic                    pop,
  output logic [23:0]             color
);

  // range needs room for 1.0 even when samples are narrow
  localparam int RW = (SAMPLE_WIDTH > FRACTION_BITS) ? SAMPLE_WIDTH : FRACTION_BITS + 1;
  localparam int QW = SAMPLE_WIDTH + 1 + RW;

  logic                         accept;
  logic                         q_push;
  logic signed [SAMPLE_WIDTH:0] f_d;
  logic [RW-1:0]                f_r;
  logic [QW-1:0]                q_rdata;
  logic                         q_full;
  logic                         q_empty;
  logic                         q_pop;
  logic                         out_valid;

  // a word enters whenever the queue has room, whatever its command
  assign full   = q_full;
  assign accept = push && !q_full;

  mnv_front #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .sample (sample),
    .q_push (q_push),
    .q_d    (f_d),
    .q_r    (f_r)
  );

  // map words carry the statistics of their own moment
  mnv_queue #(
    .DATA_WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata ({f_d, f_r}),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  mnv_back #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_d       ($signed(q_rdata[QW-1:RW])),
    .q_r       (q_rdata[RW-1:0]),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .color     (color)
  );

  assign empty = !out_valid;

endmodule

>>> tb/colormap_checker.sv
// ----------------------------------------------------------------------------
// colormap_checker: pixel predictor and scoreboard for the viridis mapper
// follows the running min/max on every accepted word, predicts the rgb pixel
// of each map word and compares it with the pixel popped from the block
// ----------------------------------------------------------------------------
module colormap_checker #(
  parameter int SAMPLE_WIDTH  = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic                    full,
  input  logic [1:0]              cmd,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic                    empty,
  input  logic                    pop,
  input  logic [23:0]             color,
  output int                      mismatches,
  output int                      pending,
  output int                      pixels_checked
);

  localparam longint ONE     = longint'(1) << FRACTION_BITS;
  localparam longint QUARTER = ONE >> 2;
  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [SAMPLE_WIDTH-1:0] lo_seen;
  logic signed [SAMPLE_WIDTH-1:0] hi_seen;
  logic [23:0]                    pixel_q [$];
  int                             errs = 0;
  int                             checked = 0;
  int                             queued = 0;

  assign mismatches     = errs;
  assign pixels_checked = checked;
  assign pending        = queued;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errs++;
  endtask

  // linear blend between two knots, floored
  function automatic logic [7:0] blend(input logic [7:0] a, input logic [7:0] b,
                                       input longint frac);
    longint num;
    num = longint'(a) * QUARTER + (longint'(b) - longint'(a)) * frac;
    return 8'(num >>> (FRACTION_BITS - 2));
  endfunction

  function automatic logic [23:0] viridis_pixel(input logic signed [SAMPLE_WIDTH-1:0] s);
    longint d;
    longint span;
    longint t;
    longint frac;
    int     seg;
    d    = longint'(s) - longint'(lo_seen);
    span = (hi_seen > lo_seen) ? longint'(hi_seen) - longint'(lo_seen) : ONE;
    if (d <= 0) t = 0;
    else if (d >= span) t = ONE;
    else t = (d <<< FRACTION_BITS) / span;
    seg = int'(t >>> (FRACTION_BITS - 2));
    if (seg >= 4) begin
      seg  = 3;
      frac = QUARTER;
    end else begin
      frac = t - longint'(seg) * QUARTER;
    end
    return {blend(mnv_pkg::KNOT_R[seg], mnv_pkg::KNOT_R[seg+1], frac),
            blend(mnv_pkg::KNOT_G[seg], mnv_pkg::KNOT_G[seg+1], frac),
            blend(mnv_pkg::KNOT_B[seg], mnv_pkg::KNOT_B[seg+1], frac)};
  endfunction

  always @(posedge clk) begin
    logic [23:0] want;
    if (rst) begin
      lo_seen = MOST_POS;
      hi_seen = MOST_NEG;
      pixel_q.delete();
    end else begin
      if (push && !full) begin
        case (cmd)
          mnv_pkg::CMD_SCAN: begin
            if ($signed(sample) < lo_seen) lo_seen = $signed(sample);
            if ($signed(sample) > hi_seen) hi_seen = $signed(sample);
          end
          mnv_pkg::CMD_MAP:   pixel_q.push_back(viridis_pixel($signed(sample)));
          mnv_pkg::CMD_CLEAR: begin
            lo_seen = MOST_POS;
            hi_seen = MOST_NEG;
          end
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pixel_q.size() == 0) begin
          report_mismatch($sformatf("pixel %06h with nothing expected", color));
        end else begin
          want = pixel_q.pop_front();
          if (color !== want)
            report_mismatch($sformatf("color %06h, expected %06h", color, want));
          checked++;
        end
      end
    end
    queued <= pixel_q.size();
  end

endmodule

>>> tb/tb_minmax_normalize_viridis_colormap.sv
// ----------------------------------------------------------------------------
// tb_minmax_normalize_viridis_colormap: testbench for the viridis color mapper
// directed words for the corner cases, then random clear/scan/map frames with
// noise, idling on both sides, a no-idle stretch and a long receiver hold-off;
// the checker predicts every pixel and this module gives the verdict
// ----------------------------------------------------------------------------
module tb_minmax_normalize_viridis_colormap;

  localparam int SAMPLE_WIDTH  = 32;
  localparam int FRACTION_BITS = 16;
  localparam int WORD_COUNT    = 1350;
  localparam int HOLD_CYCLES   = 600;
  // command value the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [SAMPLE_WIDTH-1:0] MOST_POS = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] MOST_NEG = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                    clk;
  logic                    rst;
  logic                    push;
  logic                    full;
  logic [1:0]              cmd;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    empty;
  logic                    pop;
  logic [23:0]             color;

  int mismatches;
  int pending;
  int pixels_checked;

  // idling knobs in percent, one for the sender and one for the receiver
  int src_idle_pct  = 27;
  int sink_idle_pct = 27;
  bit hold_req      = 1'b0;
  bit hold_done     = 1'b0;
  int hold_left     = 0;

  // run statistics for the summary
  int words_sent  = 0;
  int n_scan      = 0;
  int n_map       = 0;
  int n_clear     = 0;
  int n_ignored   = 0;
  int full_cycles = 0;

  minmax_normalize_viridis_colormap #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .cmd   (cmd),
    .sample(sample),
    .empty (empty),
    .pop   (pop),
    .color (color)
  );

  colormap_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRACTION_BITS(FRACTION_BITS)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .cmd           (cmd),
    .sample        (sample),
    .empty         (empty),
    .pop           (pop),
    .color         (color),
    .mismatches    (mismatches),
    .pending       (pending),
    .pixels_checked(pixels_checked)
  );

  // 10 unit clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #6_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random pop, plus a long hold-off counted here on request
  initial begin
    pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // offer one word and hold it until the block takes it
  task automatic send_word(input logic [1:0] op, input logic [SAMPLE_WIDTH-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    cmd    <= op;
    sample <= val;
    @(posedge clk);
    while (full) begin
      full_cycles++;
      @(posedge clk);
    end
    case (op)
      mnv_pkg::CMD_SCAN:  n_scan++;
      mnv_pkg::CMD_MAP:   n_map++;
      mnv_pkg::CMD_CLEAR: n_clear++;
      default:            n_ignored++;
    endcase
    if (op != CMD_UNUSED) words_sent++;
  endtask

  // value at a random offset below 2^mag above base (wraps freely)
  function automatic logic [SAMPLE_WIDTH-1:0] near(input logic [SAMPLE_WIDTH-1:0] base,
                                                   input int mag);
    logic [SAMPLE_WIDTH-1:0] mask;
    mask = SAMPLE_WIDTH'((longint'(1) << mag) - 1);
    return base + ($urandom & mask);
  endfunction

  // one clear/scan/map frame: the path that reaches the divider and colormap
  task automatic send_frame(input int max_maps);
    logic [SAMPLE_WIDTH-1:0] lo;
    logic [SAMPLE_WIDTH-1:0] val;
    int                      mag;
    int                      pick;
    lo  = $urandom;
    mag = $urandom_range(0, 31);
    if ($urandom_range(99) < 80) send_word(mnv_pkg::CMD_CLEAR, $urandom);
    repeat ($urandom_range(1, 6)) send_word(mnv_pkg::CMD_SCAN, near(lo, mag));
    repeat ($urandom_range(1, max_maps)) begin
      pick = $urandom_range(99);
      if (pick < 75) val = near(lo, mag);
      else if (pick < 85) val = lo - near('0, $urandom_range(0, 20));
      else if (pick < 93) val = near(lo, mag) + near('0, mag);
      else val = $urandom;
      // an occasional late scan widens the span between maps
      if ($urandom_range(99) < 10)
        send_word(mnv_pkg::CMD_SCAN, near(lo, mag + ($urandom_range(0, 1))));
      send_word(mnv_pkg::CMD_MAP, val);
    end
  endtask

  // random traffic: mostly frames, some noise including the unused command
  task automatic random_until(input int target);
    while (words_sent < target) begin
      if ($urandom_range(99) < 15)
        repeat ($urandom_range(1, 4)) send_word(2'($urandom_range(0, 3)), $urandom);
      else
        send_frame(10);
    end
  endtask

  initial begin
    rst    = 1'b1;
    push   = 1'b0;
    cmd    = mnv_pkg::CMD_SCAN;
    sample = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // map before any scan: reset statistics force t to zero
    send_word(mnv_pkg::CMD_MAP, '0);
    send_word(mnv_pkg::CMD_MAP, MOST_POS);
    send_word(CMD_UNUSED, '1);
    // widest possible span, extremes map to both ends
    send_word(mnv_pkg::CMD_SCAN, MOST_NEG);
    send_word(mnv_pkg::CMD_SCAN, MOST_POS);
    send_word(mnv_pkg::CMD_MAP, MOST_NEG);
    send_word(mnv_pkg::CMD_MAP, MOST_POS);
    send_word(mnv_pkg::CMD_MAP, '0);
    // span of 4.0 puts the maps exactly on the knots, the last one just below
    send_word(mnv_pkg::CMD_CLEAR, '0);
    send_word(mnv_pkg::CMD_SCAN, '0);
    send_word(mnv_pkg::CMD_SCAN, 32'h0004_0000);
    send_word(mnv_pkg::CMD_MAP, 32'h0001_0000);
    send_word(mnv_pkg::CMD_MAP, 32'h0002_0000);
    send_word(mnv_pkg::CMD_MAP, 32'h0003_0000);
    send_word(mnv_pkg::CMD_MAP, 32'h0003_FFFF);
    // outside the scanned span: saturates low and high
    send_word(mnv_pkg::CMD_MAP, 32'hFFFF_FFFF);
    send_word(mnv_pkg::CMD_MAP, 32'h0005_0000);
    // constant data falls back to a range of 1.0
    send_word(mnv_pkg::CMD_CLEAR, '1);
    send_word(mnv_pkg::CMD_SCAN, 32'h0000_1234);
    send_word(mnv_pkg::CMD_MAP, 32'h0000_1234);
    send_word(mnv_pkg::CMD_MAP, 32'h0000_1235);
    // map right after clear, then a negative constant
    send_word(mnv_pkg::CMD_CLEAR, 32'h5555_5555);
    send_word(mnv_pkg::CMD_MAP, 32'h5555_5555);
    send_word(mnv_pkg::CMD_SCAN, 32'hAAAA_AAAA);
    send_word(mnv_pkg::CMD_MAP, 32'hAAAA_AAAA);

    random_until(400);

    // back-to-back stretch, neither side idles
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    random_until(700);
    src_idle_pct  = 27;
    sink_idle_pct = 27;

    // receiver holds off while maps keep coming, so the block fills and stalls
    hold_req = 1'b1;
    send_word(mnv_pkg::CMD_CLEAR, '0);
    send_word(mnv_pkg::CMD_SCAN, 32'hFFF0_0000);
    send_word(mnv_pkg::CMD_SCAN, 32'h0010_0000);
    repeat (16) send_word(mnv_pkg::CMD_MAP, near(32'hFFF0_0000, 21));

    random_until(WORD_COUNT);
    push <= 1'b0;

    // drain: wait for every pixel, then keep the clock running to catch strays
    do @(posedge clk); while (pending != 0);
    repeat (4 * (FRACTION_BITS + 3)) @(posedge clk);

    $display("covered %0d scan, %0d map, %0d clear and %0d unused-command words",
             n_scan, n_map, n_clear, n_ignored);
    $display("%0d pixels checked, input stalled on full for %0d cycles",
             pixels_checked, full_cycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
